/* sv/assert_macros.svh */
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, off during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on the rising edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/sem_pkg.sv */
package sem_pkg;

	localparam logic [3:0] MAX_RELAYS = 4'd8;

	localparam logic [2:0] REG_SWITCH_TYPE       = 3'd0;
	localparam logic [2:0] REG_SWITCH_ACTION     = 3'd1;
	localparam logic [2:0] REG_RELAY_ATTACH_MODE = 3'd2;
	localparam logic [2:0] REG_BIND_ATTACH_MODE  = 3'd3;
	localparam logic [2:0] REG_RELAY_NUMBER      = 3'd4;
	localparam logic [2:0] REG_RELAY_TOTAL       = 3'd5;
	localparam logic [2:0] REG_INDICATOR_PRESENT = 3'd6;
	localparam logic [2:0] REG_MOVE_RATE         = 3'd7;

	localparam logic [1:0] SW_TOGGLE = 2'd0;

	localparam logic [2:0] ACT_ON_OFF     = 3'd0;
	localparam logic [2:0] ACT_OFF_ON     = 3'd1;
	localparam logic [2:0] ACT_TOGGLE     = 3'd2;
	localparam logic [2:0] ACT_SMART_SYNC = 3'd3;
	localparam logic [2:0] ACT_SMART_OPP  = 3'd4;

	localparam logic [1:0] RA_DETACHED = 2'd0;
	localparam logic [1:0] RA_PRESS    = 2'd1;
	localparam logic [1:0] RA_RELEASE  = 2'd2;
	localparam logic [1:0] RA_HOLD     = 2'd3;

	localparam logic [1:0] BA_PRESS   = 2'd0;
	localparam logic [1:0] BA_RELEASE = 2'd1;
	localparam logic [1:0] BA_HOLD    = 2'd2;

	localparam logic [1:0] EV_PRESS   = 2'd0;
	localparam logic [1:0] EV_RELEASE = 2'd1;
	localparam logic [1:0] EV_HOLD    = 2'd2;

	localparam logic [1:0] KIND_ON     = 2'd0;
	localparam logic [1:0] KIND_OFF    = 2'd1;
	localparam logic [1:0] KIND_TOGGLE = 2'd2;

	localparam logic [1:0] LVL_NONE = 2'd0;
	localparam logic [1:0] LVL_MOVE = 2'd1;
	localparam logic [1:0] LVL_STOP = 2'd2;

	localparam logic [2:0] POS_RELEASED = 3'd0;
	localparam logic [2:0] POS_PRESSED  = 3'd1;
	localparam logic [2:0] POS_LONG     = 3'd2;
	localparam logic [2:0] POS_ON       = 3'd3;
	localparam logic [2:0] POS_OFF      = 3'd4;

	typedef struct packed {
		logic [1:0] switch_type;
		logic [2:0] switch_action;
		logic [1:0] relay_attach_mode;
		logic [1:0] bind_attach_mode;
		logic [3:0] relay_number;
		logic [3:0] relay_total;
		logic       indicator_present;
		logic [7:0] move_rate;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       net_joined;
		logic       relay_on_now;
		logic       led_idle;
	} item_t;

	typedef struct packed {
		logic [2:0] position;
		logic       next_dir;
	} state_t;

	typedef struct packed {
		logic       relay_req_valid;
		logic [1:0] relay_req_kind;
		logic       relay_req_source;
		logic [2:0] relay_req_id;
		logic       bind_cmd_valid;
		logic [1:0] bind_cmd_kind;
		logic [1:0] level_cmd;
		logic       level_dir;
		logic [7:0] level_rate_out;
		logic       flash_req;
		logic [2:0] position_value;
	} result_t;

endpackage

/* sv/sem_cfg.sv */
module sem_cfg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output sem_pkg::cfg_t     cfg
);

	sem_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sem_pkg::REG_SWITCH_TYPE: begin
					cfg_q.switch_type <= cfg_data[1:0];
				end
				sem_pkg::REG_SWITCH_ACTION: begin
					cfg_q.switch_action <= cfg_data[2:0];
				end
				sem_pkg::REG_RELAY_ATTACH_MODE: begin
					cfg_q.relay_attach_mode <= cfg_data[1:0];
				end
				sem_pkg::REG_BIND_ATTACH_MODE: begin
					cfg_q.bind_attach_mode <= cfg_data[1:0];
				end
				sem_pkg::REG_RELAY_NUMBER: begin
					cfg_q.relay_number <= cfg_data[3:0];
				end
				sem_pkg::REG_RELAY_TOTAL: begin
					cfg_q.relay_total <= cfg_data[3:0];
				end
				sem_pkg::REG_INDICATOR_PRESENT: begin
					cfg_q.indicator_present <= cfg_data[0];
				end
				sem_pkg::REG_MOVE_RATE: begin
					cfg_q.move_rate <= cfg_data;
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

endmodule

/* sv/sem_decide.sv */
module sem_decide (
	input  sem_pkg::cfg_t    cfg,
	input  sem_pkg::item_t   item,
	input  sem_pkg::state_t  state,
	output sem_pkg::result_t res,
	output sem_pkg::state_t  state_next
);

	logic       relay_ok;
	logic       attached;
	logic       flash_ok;
	logic       toggle_sw;
	logic       do_relay;
	logic       do_bind;
	logic       second;
	logic       rk_has;
	logic [1:0] rk;
	logic       bk_has;
	logic [1:0] bk;
	logic       r_valid;
	logic [1:0] r_kind;
	logic       r_src;

	assign relay_ok = (cfg.relay_number != 4'd0) && (cfg.relay_number <= cfg.relay_total) &&
		(cfg.relay_number <= sem_pkg::MAX_RELAYS);
	assign attached  = (cfg.relay_attach_mode != sem_pkg::RA_DETACHED) && relay_ok;
	assign flash_ok  = cfg.indicator_present && !attached && item.led_idle;
	assign toggle_sw = (cfg.switch_type == sem_pkg::SW_TOGGLE);

	always_comb begin
		state_next         = state;
		res                = '0;
		do_relay           = 1'b0;
		do_bind            = 1'b0;
		second             = 1'b0;
		r_valid            = 1'b0;
		r_kind             = sem_pkg::KIND_ON;
		r_src              = 1'b0;
		case (item.mode)
			sem_pkg::EV_PRESS: begin
				res.flash_req = flash_ok;
				if (toggle_sw) begin
					do_relay            = (cfg.relay_attach_mode != sem_pkg::RA_DETACHED);
					do_bind             = 1'b1;
					state_next.position = sem_pkg::POS_ON;
				end else begin
					do_relay            = (cfg.relay_attach_mode == sem_pkg::RA_PRESS);
					do_bind             = (cfg.bind_attach_mode == sem_pkg::BA_PRESS);
					state_next.position = sem_pkg::POS_PRESSED;
				end
			end
			sem_pkg::EV_RELEASE: begin
				if (toggle_sw) begin
					res.flash_req       = flash_ok;
					do_relay            = (cfg.relay_attach_mode != sem_pkg::RA_DETACHED);
					do_bind             = 1'b1;
					second              = 1'b1;
					state_next.position = sem_pkg::POS_OFF;
				end else begin
					if (state.position != sem_pkg::POS_LONG) begin
						do_relay = (cfg.relay_attach_mode == sem_pkg::RA_RELEASE);
						do_bind  = (cfg.bind_attach_mode == sem_pkg::BA_RELEASE);
					end else if (item.net_joined) begin
						res.level_cmd = sem_pkg::LVL_STOP;
					end
					state_next.position = sem_pkg::POS_RELEASED;
				end
			end
			sem_pkg::EV_HOLD: begin
				if (!toggle_sw) begin
					if ((cfg.relay_attach_mode == sem_pkg::RA_HOLD) && relay_ok) begin
						r_valid = 1'b1;
						r_kind  = sem_pkg::KIND_TOGGLE;
						r_src   = 1'b1;
					end
					do_bind = (cfg.bind_attach_mode == sem_pkg::BA_HOLD);
					if (item.net_joined) begin
						res.level_cmd       = sem_pkg::LVL_MOVE;
						res.level_dir       = state.next_dir;
						res.level_rate_out  = cfg.move_rate;
						state_next.next_dir = !state.next_dir;
					end
					state_next.position = sem_pkg::POS_LONG;
				end
			end
			default: begin
				state_next = state;
			end
		endcase

		rk_has = 1'b1;
		case (cfg.switch_action)
			sem_pkg::ACT_ON_OFF: begin
				rk = second ? sem_pkg::KIND_OFF : sem_pkg::KIND_ON;
			end
			sem_pkg::ACT_OFF_ON: begin
				rk = second ? sem_pkg::KIND_ON : sem_pkg::KIND_OFF;
			end
			sem_pkg::ACT_TOGGLE, sem_pkg::ACT_SMART_SYNC, sem_pkg::ACT_SMART_OPP: begin
				rk = sem_pkg::KIND_TOGGLE;
			end
			default: begin
				rk     = sem_pkg::KIND_ON;
				rk_has = 1'b0;
			end
		endcase

		bk_has = 1'b1;
		case (cfg.switch_action)
			sem_pkg::ACT_ON_OFF: begin
				bk = second ? sem_pkg::KIND_OFF : sem_pkg::KIND_ON;
			end
			sem_pkg::ACT_OFF_ON: begin
				bk = second ? sem_pkg::KIND_ON : sem_pkg::KIND_OFF;
			end
			sem_pkg::ACT_TOGGLE: begin
				bk = sem_pkg::KIND_TOGGLE;
			end
			sem_pkg::ACT_SMART_SYNC: begin
				if (!relay_ok) begin
					bk = sem_pkg::KIND_TOGGLE;
				end else begin
					bk = item.relay_on_now ? sem_pkg::KIND_ON : sem_pkg::KIND_OFF;
				end
			end
			sem_pkg::ACT_SMART_OPP: begin
				if (!relay_ok) begin
					bk = sem_pkg::KIND_TOGGLE;
				end else begin
					bk = item.relay_on_now ? sem_pkg::KIND_OFF : sem_pkg::KIND_ON;
				end
			end
			default: begin
				bk     = sem_pkg::KIND_ON;
				bk_has = 1'b0;
			end
		endcase

		if (do_relay && relay_ok && rk_has) begin
			r_valid = 1'b1;
			r_kind  = rk;
			r_src   = 1'b0;
		end
		if (do_bind && item.net_joined && bk_has) begin
			res.bind_cmd_valid = 1'b1;
			res.bind_cmd_kind  = bk;
		end

		res.relay_req_valid = r_valid;
		if (r_valid) begin
			res.relay_req_kind   = r_kind;
			res.relay_req_source = r_src;
			res.relay_req_id     = 3'(cfg.relay_number - 4'd1);
		end
		res.position_value = state_next.position;
	end

endmodule

/* sv/switch_event_action_mapper.sv */
// Wall-switch event to action mapper.
// Input channel (in_valid/in_ready) takes one switch event per item: press,
// release or hold start, with the network-joined flag, the relay state and
// the indicator-idle flag. The output channel (out_valid/out_ready) gives one
// result item per input item, in order, with the relay request, bound-device
// command, level move or stop, flash request and the new switch position.
// The configuration channel (cfg_valid/cfg_ready) writes one register per
// item and is always ready; write it only while no item is in flight.
// An accepted item is captured in the input register, is decided in a single
// pass and is captured in the result register that drives the outputs; the
// block takes one item per cycle while out_ready stays high.
// The switch position and the move direction update as the item leaves the
// input register. When the receiver stalls, the result register holds and
// the input register fills; in_ready then drops until out_ready returns.
// Reset clears the configuration and both valid flags, sets the position to
// released and the move direction to 0, and so empties both pipeline stages.
module switch_event_action_mapper (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] mode,
	input  logic       net_joined,
	input  logic       relay_on_now,
	input  logic       led_idle,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       relay_req_valid,
	output logic [1:0] relay_req_kind,
	output logic       relay_req_source,
	output logic [2:0] relay_req_id,
	output logic       bind_cmd_valid,
	output logic [1:0] bind_cmd_kind,
	output logic [1:0] level_cmd,
	output logic       level_dir,
	output logic [7:0] level_rate_out,
	output logic       flash_req,
	output logic [2:0] position_value
);

	sem_pkg::cfg_t    cfg;
	sem_pkg::item_t   item_s1;
	logic             valid_s1;
	sem_pkg::result_t res_s2;
	logic             valid_s2;
	sem_pkg::state_t  state_q;
	sem_pkg::state_t  state_next;
	sem_pkg::result_t res_next;
	logic             adv_s1;
	logic             take_in;

	sem_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sem_decide u_decide (
		.cfg        (cfg),
		.item       (item_s1),
		.state      (state_q),
		.res        (res_next),
		.state_next (state_next)
	);

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign take_in  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{position: sem_pkg::POS_RELEASED, next_dir: 1'b0};
		end else begin
			if (take_in) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= '{mode: mode, net_joined: net_joined,
				relay_on_now: relay_on_now, led_idle: led_idle};
		end
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid        = valid_s2;
	assign relay_req_valid  = res_s2.relay_req_valid;
	assign relay_req_kind   = res_s2.relay_req_kind;
	assign relay_req_source = res_s2.relay_req_source;
	assign relay_req_id     = res_s2.relay_req_id;
	assign bind_cmd_valid   = res_s2.bind_cmd_valid;
	assign bind_cmd_kind    = res_s2.bind_cmd_kind;
	assign level_cmd        = res_s2.level_cmd;
	assign level_dir        = res_s2.level_dir;
	assign level_rate_out   = res_s2.level_rate_out;
	assign flash_req        = res_s2.flash_req;
	assign position_value   = res_s2.position_value;

endmodule

/* sv/sem_checker.sv */
`include "assert_macros.svh"

module sem_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       relay_req_valid,
	input logic [1:0] relay_req_kind,
	input logic       relay_req_source,
	input logic [2:0] relay_req_id,
	input logic       bind_cmd_valid,
	input logic [1:0] bind_cmd_kind,
	input logic [1:0] level_cmd,
	input logic       level_dir,
	input logic [7:0] level_rate_out,
	input logic [2:0] position_value
);

	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(position_value) && $stable(level_cmd))

	`ASSERT_IMP(a_relay_idle_zero, clk, arst_n, out_valid && !relay_req_valid,
		relay_req_kind == 2'd0 && !relay_req_source && relay_req_id == 3'd0)

	`ASSERT_IMP(a_bind_idle_zero, clk, arst_n, out_valid && !bind_cmd_valid,
		bind_cmd_kind == 2'd0)

	`ASSERT_IMP(a_move_fields, clk, arst_n, out_valid && level_cmd != sem_pkg::LVL_MOVE,
		!level_dir && level_rate_out == 8'd0)

	`ASSERT_IMP(a_hold_relay_pos, clk, arst_n, out_valid && relay_req_valid && relay_req_source,
		position_value == sem_pkg::POS_LONG && level_cmd != sem_pkg::LVL_STOP)

endmodule

bind switch_event_action_mapper sem_checker u_sem_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.relay_req_valid  (relay_req_valid),
	.relay_req_kind   (relay_req_kind),
	.relay_req_source (relay_req_source),
	.relay_req_id     (relay_req_id),
	.bind_cmd_valid   (bind_cmd_valid),
	.bind_cmd_kind    (bind_cmd_kind),
	.level_cmd        (level_cmd),
	.level_dir        (level_dir),
	.level_rate_out   (level_rate_out),
	.position_value   (position_value)
);
